FILE: src/yuvtpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuvtpg_pkg
// Shared types, constants and the color bar table of the 4:2:0 pattern source.
// ----------------------------------------------------------------------------
package yuvtpg_pkg;

    localparam int MAX_DIMENSION_DEF = 4096;
    localparam int CHECKER_TILE_DEF  = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int PIX_W      = 12;
    localparam int SAMPLE_W   = 8;

    localparam int MIN_WIDTH  = 8;
    localparam int MIN_HEIGHT = 2;
    localparam int GRAD_SCALE = 219;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = CFG_DATA_W'(1280);
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = CFG_DATA_W'(720);

    localparam logic [SAMPLE_W-1:0] Y_BLACK   = 8'd16;
    localparam logic [SAMPLE_W-1:0] Y_WHITE   = 8'd235;
    localparam logic [SAMPLE_W-1:0] C_NEUTRAL = 8'd128;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_SELECT = 2'd2;

    typedef enum logic [1:0] {
        PAT_BARS     = 2'd0,
        PAT_GRADIENT = 2'd1,
        PAT_CHECKER  = 2'd2,
        PAT_BLACK    = 2'd3
    } t_pattern;

    typedef struct packed {
        logic [SAMPLE_W-1:0] y;
        logic [SAMPLE_W-1:0] cb;
        logic [SAMPLE_W-1:0] cr;
    } t_yuv;

    typedef struct packed {
        logic start;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_dp_stat;

    function automatic t_yuv bar_colour(input logic [2:0] idx);
        t_yuv c;
        unique case (idx)
            3'd0:    c = '{y: 8'd235, cb: 8'd128, cr: 8'd128};
            3'd1:    c = '{y: 8'd210, cb: 8'd16,  cr: 8'd146};
            3'd2:    c = '{y: 8'd170, cb: 8'd166, cr: 8'd16};
            3'd3:    c = '{y: 8'd145, cb: 8'd54,  cr: 8'd34};
            3'd4:    c = '{y: 8'd106, cb: 8'd202, cr: 8'd222};
            3'd5:    c = '{y: 8'd81,  cb: 8'd90,  cr: 8'd240};
            3'd6:    c = '{y: 8'd41,  cb: 8'd240, cr: 8'd110};
            default: c = '{y: 8'd16,  cb: 8'd128, cr: 8'd128};
        endcase
        return c;
    endfunction

endpackage

FILE: src/yuvtpg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuvtpg interfaces
// Request, pixel and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface yuvtpg_req_if;
    logic valid;
    logic ready;
    logic pixel_request;

    modport source (output valid, output pixel_request, input ready);
    modport sink   (input valid, input pixel_request, output ready);
endinterface

interface yuvtpg_pix_if;
    logic        valid;
    logic        ready;
    logic [7:0]  luma;
    logic [7:0]  chroma_blue;
    logic [7:0]  chroma_red;
    logic        chroma_valid;
    logic [11:0] pixel_column;
    logic [11:0] pixel_row;
    logic        end_of_line;
    logic        end_of_frame;

    modport source (
        output valid, output luma, output chroma_blue, output chroma_red,
        output chroma_valid, output pixel_column, output pixel_row,
        output end_of_line, output end_of_frame, input ready
    );
    modport sink (
        input valid, input luma, input chroma_blue, input chroma_red,
        input chroma_valid, input pixel_column, input pixel_row,
        input end_of_line, input end_of_frame, output ready
    );
endinterface

interface yuvtpg_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [12:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/yuv420_test_pattern_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv420_test_pattern_generator_unit
// Raster-order 4:2:0 studio-range test pattern source.
// ----------------------------------------------------------------------------
// i_req carries one request beat per pixel; a beat with pixel_request low is
// taken and dropped. o_pix returns one beat per request: Y, Cb/Cr at even
// row and column sites, position and end-of-line / end-of-frame flags.
// i_cfg writes frame width (0), frame height (1) and pattern (2); the user is
// to write only while the unit is idle, which the unit does not enforce.
// A dimension write restarts the frame at row 0, column 0. Each pixel runs
// through a restoring divider (bar index or gradient step), one quotient bit
// per cycle over CNT_W + 8 bits, CNT_W = clog2(MAX_DIMENSION). No new request
// is taken until the last one has been loaded into the output register, and
// no request is taken in the cycle that loads the output register.
// A finished pixel waits in the output register while the next request is
// taken and computed; while the receiver stalls, that next pixel holds in
// the datapath and no further request is taken.
// Reset restores 1280 x 720, color bars and position zero, and empties the
// output register.
// ----------------------------------------------------------------------------
module yuv420_test_pattern_generator_unit #(
    parameter int MAX_DIMENSION = yuvtpg_pkg::MAX_DIMENSION_DEF,
    parameter int CHECKER_TILE  = yuvtpg_pkg::CHECKER_TILE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    yuvtpg_req_if.sink    i_req,
    yuvtpg_cfg_if.sink    i_cfg,
    yuvtpg_pix_if.source  o_pix
);
    import yuvtpg_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    yuvtpg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    yuvtpg_dp #(
        .MAX_DIMENSION (MAX_DIMENSION),
        .CHECKER_TILE  (CHECKER_TILE)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_pix   (o_pix),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

endmodule

FILE: src/yuvtpg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuvtpg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module yuvtpg_div #(
    parameter int DVD_W = 20,
    parameter int DVS_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [DVD_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic [DVS_W-1:0] r_rem,  n_rem;
    logic [DVD_W-1:0] r_quo,  n_quo;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   shifted;
    logic             fits;

    always_comb begin
        shifted = {r_rem, r_quo[DVD_W-1]};
        fits    = (shifted >= {1'b0, r_dvs});
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        if (i_start) begin
            n_cnt = CNT_W'(DVD_W);
            n_rem = '0;
            n_quo = i_dividend;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - CNT_W'(1);
            n_rem = fits ? DVS_W'(shifted - {1'b0, r_dvs}) : DVS_W'(shifted);
            n_quo = {r_quo[DVD_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;

endmodule

FILE: src/yuvtpg_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuvtpg_dp
// Datapath: configuration registers, raster counters, divider and output beat.
// ----------------------------------------------------------------------------
module yuvtpg_dp #(
    parameter int MAX_DIMENSION = yuvtpg_pkg::MAX_DIMENSION_DEF,
    parameter int CHECKER_TILE  = yuvtpg_pkg::CHECKER_TILE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    yuvtpg_cfg_if.sink            i_cfg,
    yuvtpg_pix_if.source          o_pix,
    input  yuvtpg_pkg::t_dp_cmd   i_cmd,
    output yuvtpg_pkg::t_dp_stat  o_stat
);
    import yuvtpg_pkg::*;

    localparam int CNT_W  = $clog2(MAX_DIMENSION);
    localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
    localparam int TILE_W = $clog2(CHECKER_TILE);
    localparam int DVD_W  = CNT_W + SAMPLE_W;

    // configuration
    logic [CFG_DATA_W-1:0] r_frame_width;
    logic [CFG_DATA_W-1:0] r_frame_height;
    t_pattern              r_pattern;
    logic                  cfg_wr;
    logic                  dim_wr;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;
    assign dim_wr      = cfg_wr && ((i_cfg.index == CFG_FRAME_WIDTH) ||
                                    (i_cfg.index == CFG_FRAME_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
            r_pattern      <= PAT_BARS;
        end else if (cfg_wr) begin
            unique case (i_cfg.index)
                CFG_FRAME_WIDTH:    r_frame_width  <= i_cfg.data;
                CFG_FRAME_HEIGHT:   r_frame_height <= i_cfg.data;
                CFG_PATTERN_SELECT: r_pattern      <= t_pattern'(i_cfg.data[1:0]);
                default: ;
            endcase
        end
    end

    // effective dimensions
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;

    always_comb begin
        if (32'(r_frame_width) > 32'(MAX_DIMENSION)) begin
            w_eff = DIM_W'(MAX_DIMENSION);
        end else if (32'(r_frame_width) < 32'(MIN_WIDTH)) begin
            w_eff = DIM_W'(MIN_WIDTH);
        end else begin
            w_eff = DIM_W'(r_frame_width);
        end
        if (32'(r_frame_height) > 32'(MAX_DIMENSION)) begin
            h_eff = DIM_W'(MAX_DIMENSION);
        end else if (32'(r_frame_height) < 32'(MIN_HEIGHT)) begin
            h_eff = DIM_W'(MIN_HEIGHT);
        end else begin
            h_eff = DIM_W'(r_frame_height);
        end
    end

    // raster position and tile phase
    logic [CNT_W-1:0]  r_col, r_row;
    logic [TILE_W-1:0] r_col_tile, r_row_tile;
    logic              r_col_par, r_row_par;
    logic              eol, eof;

    assign eol = (32'(r_col) + 32'd1) >= 32'(w_eff);
    assign eof = eol && ((32'(r_row) + 32'd1) >= 32'(h_eff));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || dim_wr) begin
            r_col      <= '0;
            r_row      <= '0;
            r_col_tile <= '0;
            r_row_tile <= '0;
            r_col_par  <= 1'b0;
            r_row_par  <= 1'b0;
        end else if (i_cmd.start) begin
            if (eol) begin
                r_col      <= '0;
                r_col_tile <= '0;
                r_col_par  <= 1'b0;
                if (eof) begin
                    r_row      <= '0;
                    r_row_tile <= '0;
                    r_row_par  <= 1'b0;
                end else begin
                    r_row <= r_row + CNT_W'(1);
                    if (32'(r_row_tile) == CHECKER_TILE - 1) begin
                        r_row_tile <= '0;
                        r_row_par  <= !r_row_par;
                    end else begin
                        r_row_tile <= r_row_tile + TILE_W'(1);
                    end
                end
            end else begin
                r_col <= r_col + CNT_W'(1);
                if (32'(r_col_tile) == CHECKER_TILE - 1) begin
                    r_col_tile <= '0;
                    r_col_par  <= !r_col_par;
                end else begin
                    r_col_tile <= r_col_tile + TILE_W'(1);
                end
            end
        end
    end

    // pixel context held while the divider runs
    logic [CNT_W-1:0] r_px_col, r_px_row;
    logic             r_px_eol, r_px_eof, r_px_site, r_px_chk;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_px_col  <= r_col;
            r_px_row  <= r_row;
            r_px_eol  <= eol;
            r_px_eof  <= eof;
            r_px_site <= !r_col[0] && !r_row[0];
            r_px_chk  <= r_col_par ^ r_row_par;
        end
    end

    // divider operands
    logic [DVD_W-1:0] dividend;
    logic [DIM_W-1:0] divisor;
    logic [DVD_W-1:0] quotient;
    logic             div_busy;

    always_comb begin
        if (r_pattern == PAT_BARS) begin
            dividend = DVD_W'(r_col);
            divisor  = w_eff >> 3;
        end else begin
            dividend = DVD_W'(r_col) * DVD_W'(GRAD_SCALE);
            divisor  = w_eff - DIM_W'(1);
        end
    end

    yuvtpg_div #(
        .DVD_W (DVD_W),
        .DVS_W (DIM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    // sample selection
    logic [2:0] bar_idx;
    t_yuv       bar;
    t_yuv       px;

    always_comb begin
        bar_idx = (|quotient[DVD_W-1:3]) ? 3'd7 : quotient[2:0];
        bar     = bar_colour(bar_idx);
        px      = '{y: Y_BLACK, cb: C_NEUTRAL, cr: C_NEUTRAL};
        unique case (r_pattern)
            PAT_BARS:     px = bar;
            PAT_GRADIENT: px.y = quotient[SAMPLE_W-1:0] + Y_BLACK;
            PAT_CHECKER:  px.y = r_px_chk ? Y_WHITE : Y_BLACK;
            default:      px.y = Y_BLACK;
        endcase
        if (!r_px_site) begin
            px.cb = C_NEUTRAL;
            px.cr = C_NEUTRAL;
        end
    end

    // output beat
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_pix.luma         <= px.y;
            o_pix.chroma_blue  <= px.cb;
            o_pix.chroma_red   <= px.cr;
            o_pix.chroma_valid <= r_px_site;
            o_pix.pixel_column <= PIX_W'(r_px_col);
            o_pix.pixel_row    <= PIX_W'(r_px_row);
            o_pix.end_of_line  <= r_px_eol;
            o_pix.end_of_frame <= r_px_eof;
        end
    end

    assign o_pix.valid     = r_out_valid;
    assign o_stat.div_done = !div_busy;
    assign o_stat.out_free = !r_out_valid || o_pix.ready;

endmodule

FILE: src/yuvtpg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuvtpg_ctrl
// Controller: takes requests and sequences divide and output load.
// ----------------------------------------------------------------------------
module yuvtpg_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    yuvtpg_req_if.sink            i_req,
    input  yuvtpg_pkg::t_dp_stat  i_stat,
    output yuvtpg_pkg::t_dp_cmd   o_cmd
);
    import yuvtpg_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_BUSY = 2'b10
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state      = r_state;
        i_req.ready  = 1'b0;
        o_cmd.start  = 1'b0;
        o_cmd.finish = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid && i_req.pixel_request) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_BUSY;
                end
            end
            S_BUSY: begin
                if (i_stat.div_done && i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
